[rtl/tmc_pkg.sv]
// Shared types, constants and register codes for the touch multi-click event detector.
`timescale 1ns / 1ps
`default_nettype none

package tmc_pkg;

  localparam int unsigned TimeBitsDefault = 32;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned TouchW = 16;
  localparam int unsigned NowW   = 32;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIdxW = 3;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] DebounceMsRst      = 16'd50;
  localparam logic [CfgW-1:0] DoubleClickGapRst  = 16'd250;
  localparam logic [CfgW-1:0] HoldTimeMsRst      = 16'd2000;
  localparam logic [CfgW-1:0] LongHoldTimeMsRst  = 16'd3000;
  localparam logic [CfgW-1:0] TouchThresholdRst  = 16'd55;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_MS      = 3'd0,
    CFG_DOUBLE_CLICK_GAP = 3'd1,
    CFG_HOLD_TIME_MS     = 3'd2,
    CFG_LONG_HOLD_MS     = 3'd3,
    CFG_TOUCH_THRESHOLD  = 3'd4
  } cfg_idx_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE         = 3'd0,
    EV_CLICK        = 3'd1,
    EV_DOUBLE_CLICK = 3'd2,
    EV_HOLD         = 3'd3,
    EV_LONG_HOLD    = 3'd4
  } event_e;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] double_click_gap_ms;
    logic [CfgW-1:0] hold_time_ms;
    logic [CfgW-1:0] long_hold_time_ms;
    logic [CfgW-1:0] touch_threshold;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/tmc_cfg_regs.sv]
// Configuration register file of the touch multi-click event detector.
`timescale 1ns / 1ps
`default_nettype none

module tmc_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tmc_pkg::CfgW-1:0]     cfg_wdata_i,
  output tmc_pkg::cfg_t                     cfg_o
);

  tmc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      // indexes beyond the list are dropped
      unique case (cfg_idx_i)
        tmc_pkg::CFG_DEBOUNCE_MS:      cfg_d.debounce_ms         = cfg_wdata_i;
        tmc_pkg::CFG_DOUBLE_CLICK_GAP: cfg_d.double_click_gap_ms = cfg_wdata_i;
        tmc_pkg::CFG_HOLD_TIME_MS:     cfg_d.hold_time_ms        = cfg_wdata_i;
        tmc_pkg::CFG_LONG_HOLD_MS:     cfg_d.long_hold_time_ms   = cfg_wdata_i;
        tmc_pkg::CFG_TOUCH_THRESHOLD:  cfg_d.touch_threshold     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms         <= tmc_pkg::DebounceMsRst;
      cfg_q.double_click_gap_ms <= tmc_pkg::DoubleClickGapRst;
      cfg_q.hold_time_ms        <= tmc_pkg::HoldTimeMsRst;
      cfg_q.long_hold_time_ms   <= tmc_pkg::LongHoldTimeMsRst;
      cfg_q.touch_threshold     <= tmc_pkg::TouchThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/tmc_in_stage.sv]
// Input register stage holding one sample beat ahead of the event logic.
`timescale 1ns / 1ps
`default_nettype none

module tmc_in_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [tmc_pkg::TouchW-1:0]  touch_value_i,
  input  wire logic [tmc_pkg::NowW-1:0]    now_ms_i,
  output      logic                        s_valid_o,
  input  wire logic                        s_take_i,
  output      logic [tmc_pkg::TouchW-1:0]  s_touch_value_o,
  output      logic [tmc_pkg::NowW-1:0]    s_now_ms_o
);

  logic                       valid_q, valid_d;
  logic [tmc_pkg::TouchW-1:0] touch_q;
  logic [tmc_pkg::NowW-1:0]   now_q;
  logic                       load;

  // free slot, or the held beat leaves this cycle
  assign in_ready_o = !valid_q || s_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (s_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      touch_q <= touch_value_i;
      now_q   <= now_ms_i;
    end
  end

  assign s_valid_o       = valid_q;
  assign s_touch_value_o = touch_q;
  assign s_now_ms_o      = now_q;

endmodule

`default_nettype wire

[rtl/tmc_event_core.sv]
// Click, double click and hold state with the per-sample event decision.
`timescale 1ns / 1ps
`default_nettype none

module tmc_event_core #(
  parameter int unsigned TIME_BITS = tmc_pkg::TimeBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tmc_pkg::cfg_t               cfg_i,
  input  wire logic                        step_i,
  input  wire logic [tmc_pkg::TouchW-1:0]  touch_value_i,
  input  wire logic [tmc_pkg::NowW-1:0]    now_ms_i,
  output tmc_pkg::event_e                  event_o
);

  typedef logic [TIME_BITS-1:0] time_t;

  logic  last_rel_q, last_rel_d;
  time_t press_q, press_d;
  time_t release_q, release_d;
  logic  ign_q, ign_d;
  logic  single_q, single_d;
  logic  hold_q, hold_d;
  logic  long_q, long_d;
  logic  dor_q, dor_d;
  logic  dp_q, dp_d;

  time_t now_t, deb_t, gap_t, hold_t, long_t;
  time_t el_rel, el_prs, el_rel_n, el_prs_n;
  logic  released, press_ok, rel_ok;
  tmc_pkg::event_e ev;

  assign now_t  = TIME_BITS'(now_ms_i);
  assign deb_t  = TIME_BITS'(cfg_i.debounce_ms);
  assign gap_t  = TIME_BITS'(cfg_i.double_click_gap_ms);
  assign hold_t = TIME_BITS'(cfg_i.hold_time_ms);
  assign long_t = TIME_BITS'(cfg_i.long_hold_time_ms);

  assign released = !(touch_value_i < cfg_i.touch_threshold);
  assign el_rel   = now_t - release_q;
  assign el_prs   = now_t - press_q;
  assign press_ok = !released && last_rel_q && (el_rel > deb_t);
  assign rel_ok   = released && !last_rel_q && (el_prs > deb_t);
  // elapsed times against the stamps as updated by this sample's edge
  assign el_rel_n = now_t - release_d;
  assign el_prs_n = now_t - press_d;

  // edge handling
  always_comb begin
    press_d   = press_q;
    release_d = release_q;
    ign_d     = ign_q;
    single_d  = single_q;
    hold_d    = hold_q;
    long_d    = long_q;
    dor_d     = dor_q;
    dp_d      = dp_q;
    ev        = tmc_pkg::EV_NONE;

    if (press_ok) begin
      press_d  = now_t;
      ign_d    = 1'b0;
      single_d = 1'b1;
      hold_d   = 1'b0;
      long_d   = 1'b0;
      dor_d    = (el_rel < gap_t) && !dor_q && dp_q;
      dp_d     = 1'b0;
    end else if (rel_ok && !ign_q) begin
      release_d = now_t;
      if (!dor_q) begin
        dp_d = 1'b1;
      end else begin
        ev       = tmc_pkg::EV_DOUBLE_CLICK;
        dor_d    = 1'b0;
        dp_d     = 1'b0;
        single_d = 1'b0;
      end
    end
  end

  // click expiry and hold tests; later checks override earlier events
  logic  ign_f, hold_f, long_f, dor_f, dp_f;
  tmc_pkg::event_e ev_f;

  always_comb begin
    ign_f  = ign_d;
    hold_f = hold_d;
    long_f = long_d;
    dor_f  = dor_d;
    dp_f   = dp_d;
    ev_f   = ev;

    if (released && (el_rel_n >= gap_t) && dp_d && !dor_d && single_d
        && (ev != tmc_pkg::EV_DOUBLE_CLICK)) begin
      ev_f = tmc_pkg::EV_CLICK;
      dp_f = 1'b0;
    end

    if (!released && (el_prs_n >= hold_t)) begin
      if (!hold_d) begin
        ev_f   = tmc_pkg::EV_HOLD;
        ign_f  = 1'b1;
        dor_f  = 1'b0;
        dp_f   = 1'b0;
        hold_f = 1'b1;
      end
      if ((el_prs_n >= long_t) && !long_d) begin
        ev_f   = tmc_pkg::EV_LONG_HOLD;
        long_f = 1'b1;
      end
    end
  end

  assign last_rel_d = released;
  assign event_o    = ev_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rel_q <= 1'b1;
      press_q    <= '0;
      release_q  <= '0;
      ign_q      <= 1'b0;
      single_q   <= 1'b0;
      hold_q     <= 1'b0;
      long_q     <= 1'b0;
      dor_q      <= 1'b0;
      dp_q       <= 1'b0;
    end else if (step_i) begin
      last_rel_q <= last_rel_d;
      press_q    <= press_d;
      release_q  <= release_d;
      ign_q      <= ign_f;
      single_q   <= single_d;
      hold_q     <= hold_f;
      long_q     <= long_f;
      dor_q      <= dor_f;
      dp_q       <= dp_f;
    end
  end

endmodule

`default_nettype wire

[rtl/touch_multi_click_event_detector_core.sv]
// Top level of the touch multi-click event detector.
`timescale 1ns / 1ps
`default_nettype none

// Touch multi-click event detector. Each input beat carries one filtered touch
// reading and the current millisecond timestamp; each produces exactly one
// output beat with an event code: none, click, double click, hold or long hold.
// A reading below touch_threshold counts as pressed. Edges are debounced
// against the time since the last press or release, and all time differences
// wrap modulo 2^TIME_BITS. One sample is taken every clock cycle when the
// output is not stalled; a beat passes the input register, then the event logic
// into the result register. The event state updates in the same cycle as the
// decision, which is what lets the next sample follow directly. Configuration
// is written through a plain write port (index 0..4 as listed in the package,
// others ignored), by the user only while the block is idle (not enforced).

module touch_multi_click_event_detector_core #(
  parameter int unsigned TIME_BITS = tmc_pkg::TimeBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [tmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tmc_pkg::CfgW-1:0]     cfg_wdata_i,
  // sample channel
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [tmc_pkg::TouchW-1:0]   touch_value_i,
  input  wire logic [tmc_pkg::NowW-1:0]     now_ms_i,
  // event channel
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [tmc_pkg::EventW-1:0]   event_code_o
);

  tmc_pkg::cfg_t               cfg;
  logic                        s_valid;
  logic                        s_take;
  logic [tmc_pkg::TouchW-1:0]  s_touch;
  logic [tmc_pkg::NowW-1:0]    s_now;
  tmc_pkg::event_e             ev;

  logic                        out_valid_q, out_valid_d;
  logic [tmc_pkg::EventW-1:0]  event_q;

  tmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tmc_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .touch_value_i   (touch_value_i),
    .now_ms_i        (now_ms_i),
    .s_valid_o       (s_valid),
    .s_take_i        (s_take),
    .s_touch_value_o (s_touch),
    .s_now_ms_o      (s_now)
  );

  // The held sample is processed once the result register is free or its
  // beat is taken in this same cycle.
  assign s_take = s_valid && (!out_valid_q || out_ready_i);

  tmc_event_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .step_i        (s_take),
    .touch_value_i (s_touch),
    .now_ms_i      (s_now),
    .event_o       (ev)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      event_q <= ev;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;

endmodule

`default_nettype wire
